// ===== sv/pcdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdu_pkg
// Types, constants and helper functions for the password check digit updater.
// ----------------------------------------------------------------------------
package pcdu_pkg;

    localparam int CHAR_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 3;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_INIT_SHIFT  = 3'd0;
    localparam logic [2:0] REG_INIT_SUM1   = 3'd1;
    localparam logic [2:0] REG_INIT_SUM2   = 3'd2;
    localparam logic [2:0] REG_INIT_XOR    = 3'd3;
    localparam logic [2:0] REG_INIT_ROT    = 3'd4;
    localparam logic [2:0] REG_INIT_WEIGHT = 3'd5;

    // feedback taps applied when the low byte shifts out a one
    localparam byte_t FB_HIGH   = 8'h84;
    localparam byte_t FB_LOW    = 8'h08;
    // high byte threshold for the first sum carry
    localparam byte_t CARRY_MIN = 8'hE5;

    // shifts the eight bits of the zero-extended character through the shift register, msb first
    function automatic shift_t shift_char(input shift_t cur, input char_t ch);
        byte_t            hi;
        byte_t            lo;
        logic [BYTE_W-1:0] bits;
        logic             hi_out;
        logic             lo_out;
        hi   = cur[SHIFT_W-1:BYTE_W];
        lo   = cur[BYTE_W-1:0];
        bits = {{(BYTE_W-CHAR_W){1'b0}}, ch};
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            hi_out = hi[0];
            lo_out = lo[0];
            hi     = {bits[k], hi[BYTE_W-1:1]};
            lo     = {hi_out, lo[BYTE_W-1:1]};
            if (lo_out)
            begin
                hi = hi ^ FB_HIGH;
                lo = lo ^ FB_LOW;
            end
        end
        return {hi, lo};
    endfunction

    function automatic logic [CNT_W-1:0] ones_count(input char_t ch);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < CHAR_W; k++)
        begin
            n = n + {{(CNT_W-1){1'b0}}, ch[k]};
        end
        return n;
    endfunction

endpackage

// ===== sv/password_check_digit_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// password_check_digit_update
// Updates seven check bytes from one password character per transaction.
// ----------------------------------------------------------------------------
// usage
//   input channel: char_code and first with in_valid / in_stall; a transaction
//   is taken on a rising edge with in_valid high and in_stall low
//   output channel: the seven check bytes with out_valid / out_stall; one
//   result transaction per input transaction, in order
//   first = 1 reloads every check byte from the init registers before the
//   character is applied
//   init registers are written over the apb port at byte address 4*i and
//   read back on prdata; pready is tied high
// datapath and throughput
//   the whole update (eight shift steps, three chained carry sums, popcount)
//   is one level of logic from the ports into the result register, so a
//   result shows in the next cycle and one transaction is taken every cycle
//   while in_stall is low; the result register doubles as the check byte state
// reset
//   rst_n clears the init registers, the check bytes and out_valid
// stall
//   while a result waits under out_stall, in_stall is raised; a result that
//   is taken in the same cycle frees the register for the next input
// ----------------------------------------------------------------------------
module password_check_digit_update
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // apb configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pcdu_pkg::ADDR_W-1:0]           paddr,
    input  logic [pcdu_pkg::DATA_W-1:0]           pwdata,
    output logic [pcdu_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pcdu_pkg::CHAR_W-1:0]           char_code,
    input  logic                                  first,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [pcdu_pkg::BYTE_W-1:0]           shift_high,
    output logic [pcdu_pkg::BYTE_W-1:0]           shift_low,
    output logic [pcdu_pkg::BYTE_W-1:0]           first_sum,
    output logic [pcdu_pkg::BYTE_W-1:0]           second_sum,
    output logic [pcdu_pkg::BYTE_W-1:0]           xor_byte,
    output logic [pcdu_pkg::BYTE_W-1:0]           rotate_add,
    output logic [pcdu_pkg::BYTE_W-1:0]           weight_sum
);

    localparam int BW = pcdu_pkg::BYTE_W;

    // init registers
    pcdu_pkg::shift_t init_shift_reg;
    pcdu_pkg::byte_t  init_sum1_reg;
    pcdu_pkg::byte_t  init_sum2_reg;
    pcdu_pkg::byte_t  init_xor_reg;
    pcdu_pkg::byte_t  init_rot_reg;
    pcdu_pkg::byte_t  init_weight_reg;

    // check byte state, also the result register
    pcdu_pkg::shift_t shift_reg;
    pcdu_pkg::byte_t  sum1_reg;
    pcdu_pkg::byte_t  sum2_reg;
    pcdu_pkg::byte_t  xor_reg;
    pcdu_pkg::byte_t  rot_reg;
    pcdu_pkg::byte_t  weight_reg;
    logic             out_valid_reg;

    pcdu_pkg::shift_t shift_next;
    pcdu_pkg::byte_t  sum1_next;
    pcdu_pkg::byte_t  sum2_next;
    pcdu_pkg::byte_t  xor_next;
    pcdu_pkg::byte_t  rot_next;
    pcdu_pkg::byte_t  weight_next;
    logic             out_valid_next;

    // state the character is applied to (init values on a first transaction)
    pcdu_pkg::shift_t base_shift;
    pcdu_pkg::byte_t  base_sum1;
    pcdu_pkg::byte_t  base_sum2;
    pcdu_pkg::byte_t  base_xor;
    pcdu_pkg::byte_t  base_rot;
    pcdu_pkg::byte_t  base_weight;

    pcdu_pkg::byte_t  char_byte;
    pcdu_pkg::byte_t  rot_in;
    logic [BW:0]      add_one;
    logic [BW:0]      add_two;
    logic [BW:0]      add_rot;
    logic             hi_carry;
    logic             cfg_write;
    logic             in_accept;
    logic             out_accept;
    logic [2:0]       reg_index;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[pcdu_pkg::ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_shift_reg  <= '0;
            init_sum1_reg   <= '0;
            init_sum2_reg   <= '0;
            init_xor_reg    <= '0;
            init_rot_reg    <= '0;
            init_weight_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                pcdu_pkg::REG_INIT_SHIFT:  init_shift_reg  <= pwdata[pcdu_pkg::SHIFT_W-1:0];
                pcdu_pkg::REG_INIT_SUM1:   init_sum1_reg   <= pwdata[BW-1:0];
                pcdu_pkg::REG_INIT_SUM2:   init_sum2_reg   <= pwdata[BW-1:0];
                pcdu_pkg::REG_INIT_XOR:    init_xor_reg    <= pwdata[BW-1:0];
                pcdu_pkg::REG_INIT_ROT:    init_rot_reg    <= pwdata[BW-1:0];
                pcdu_pkg::REG_INIT_WEIGHT: init_weight_reg <= pwdata[BW-1:0];
                default: ;  // unmapped addresses drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            pcdu_pkg::REG_INIT_SHIFT:
                prdata = {{(pcdu_pkg::DATA_W-pcdu_pkg::SHIFT_W){1'b0}}, init_shift_reg};
            pcdu_pkg::REG_INIT_SUM1:   prdata = {{(pcdu_pkg::DATA_W-BW){1'b0}}, init_sum1_reg};
            pcdu_pkg::REG_INIT_SUM2:   prdata = {{(pcdu_pkg::DATA_W-BW){1'b0}}, init_sum2_reg};
            pcdu_pkg::REG_INIT_XOR:    prdata = {{(pcdu_pkg::DATA_W-BW){1'b0}}, init_xor_reg};
            pcdu_pkg::REG_INIT_ROT:    prdata = {{(pcdu_pkg::DATA_W-BW){1'b0}}, init_rot_reg};
            pcdu_pkg::REG_INIT_WEIGHT: prdata = {{(pcdu_pkg::DATA_W-BW){1'b0}}, init_weight_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: the result register frees up when empty or being taken
    // ------------------------------------------------------------------
    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    // ------------------------------------------------------------------
    // update logic
    // ------------------------------------------------------------------
    always_comb
    begin
        // first reloads everything from the init registers
        base_shift  = first ? init_shift_reg  : shift_reg;
        base_sum1   = first ? init_sum1_reg   : sum1_reg;
        base_sum2   = first ? init_sum2_reg   : sum2_reg;
        base_xor    = first ? init_xor_reg    : xor_reg;
        base_rot    = first ? init_rot_reg    : rot_reg;
        base_weight = first ? init_weight_reg : weight_reg;

        char_byte  = {{(BW-pcdu_pkg::CHAR_W){1'b0}}, char_code};
        shift_next = pcdu_pkg::shift_char(base_shift, char_code);

        // carry chain: high byte threshold -> first sum -> second sum -> rotate-add
        hi_carry  = (shift_next[pcdu_pkg::SHIFT_W-1:BW] >= pcdu_pkg::CARRY_MIN);
        add_one   = {1'b0, base_sum1} + {1'b0, char_byte} + {{BW{1'b0}}, hi_carry};
        add_two   = {1'b0, base_sum2} + {1'b0, shift_next[BW-1:0]}
                    + {{BW{1'b0}}, add_one[BW]};
        rot_in    = {add_two[BW], base_rot[BW-1:1]};
        add_rot   = {1'b0, rot_in} + {1'b0, char_byte} + {{BW{1'b0}}, base_rot[0]};

        sum1_next   = add_one[BW-1:0];
        sum2_next   = add_two[BW-1:0];
        xor_next    = base_xor ^ char_byte;
        rot_next    = add_rot[BW-1:0];
        weight_next = base_weight
                      + {{(BW-pcdu_pkg::CNT_W){1'b0}}, pcdu_pkg::ones_count(char_code)}
                      + {{(BW-1){1'b0}}, add_rot[BW]};

        out_valid_next = in_accept | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            sum1_reg      <= '0;
            sum2_reg      <= '0;
            xor_reg       <= '0;
            rot_reg       <= '0;
            weight_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                shift_reg  <= shift_next;
                sum1_reg   <= sum1_next;
                sum2_reg   <= sum2_next;
                xor_reg    <= xor_next;
                rot_reg    <= rot_next;
                weight_reg <= weight_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign shift_high = shift_reg[pcdu_pkg::SHIFT_W-1:BW];
    assign shift_low  = shift_reg[BW-1:0];
    assign first_sum  = sum1_reg;
    assign second_sum = sum2_reg;
    assign xor_byte   = xor_reg;
    assign rotate_add = rot_reg;
    assign weight_sum = weight_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every taken input leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("no result after accepted input");

    // the input side only stalls on a held result
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with free result register");

    // a continuing character folds into the running xor byte
    a_xor_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !first) |=>
            (xor_byte == ($past(xor_reg) ^ {{(BW-pcdu_pkg::CHAR_W){1'b0}}, $past(char_code)})))
        else $error("xor byte does not follow the character");

    // state only moves with an accepted input
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(shift_reg) && $stable(weight_reg) && $stable(rot_reg)))
        else $error("check bytes changed without input");

endmodule
